### rtl/radius_attribute_stream_parser_defines.svh
// Assertion macros shared by the parser's checker.
// Depends on nothing; the user supplies signals named clock and reset.
`ifndef RADIUS_ATTRIBUTE_STREAM_PARSER_DEFINES_SVH
`define RADIUS_ATTRIBUTE_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RAP_ASSERT_NOW(lbl, cond, conseq, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RAP_ASSERT_NEXT(lbl, cond, conseq, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

### rtl/rap_pkg.sv
// Types, codes and helpers for the RADIUS attribute stream parser.
// Depends on nothing; used by all parser modules and the checker.
package rap_pkg;

   localparam int unsigned RESULT_DEPTH = 4;
   localparam logic [7:0]  MIN_ATTR_LEN = 8'd2;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_TYPE   = 5'b00010,
      PH_LENGTH = 5'b00100,
      PH_VALUE  = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      K_HEADER    = 3'd0,
      K_VALUE     = 3'd1,
      K_EMPTY     = 3'd2,
      K_TRUNC     = 3'd3,
      K_MALFORMED = 3'd4,
      K_END       = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  packet_code;
      logic [7:0]  packet_identifier;
      logic [15:0] header_length;
      logic [7:0]  attr_type;
      logic [7:0]  attr_length;
      logic [7:0]  value_byte;
      logic [7:0]  value_index;
      logic        last_of_attr;
   } result_type;

   // Up to two results come out of one byte, first one goes out first.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic result_type make_result(
      input kind_type    kind,
      input logic        with_attr,
      input logic [7:0]  code,
      input logic [7:0]  ident,
      input logic [15:0] hlen,
      input logic [7:0]  atype,
      input logic [7:0]  alen,
      input logic [7:0]  vbyte,
      input logic [7:0]  vidx,
      input logic        vlast
   );
      result_type r;
      r.kind              = kind;
      r.packet_code       = code;
      r.packet_identifier = ident;
      r.header_length     = hlen;
      r.attr_type         = with_attr ? atype : 8'd0;
      r.attr_length       = with_attr ? alen : 8'd0;
      r.value_byte        = vbyte;
      r.value_index       = vidx;
      r.last_of_attr      = vlast;
      return r;
   endfunction

endpackage

### rtl/rap_step.sv
// Parse state and per-byte decode: one byte in, up to two results out.
// Depends on rap_pkg.
module rap_step #(
   parameter int HEADER_BYTES = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output rap_pkg::push_type push
);
   import rap_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] limit_ff, limit_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  ident_ff, ident_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;

   logic [16:0] off_inc;
   logic        stop;
   logic        hdr_done;
   logic        fin;
   logic        finish;
   logic [8:0]  value_len;

   assign off_inc   = {1'b0, offset_ff} + 17'd1;
   assign stop      = last_byte || (off_inc >= {1'b0, limit_ff});
   assign hdr_done  = off_inc >= 17'(HEADER_BYTES);
   assign value_len = {1'b0, length_ff} - {1'b0, MIN_ATTR_LEN};
   assign fin       = ({1'b0, count_ff} + 9'd1) >= value_len;

   always_comb begin
      phase_in   = phase_ff;
      limit_in   = limit_ff;
      code_in    = code_ff;
      ident_in   = ident_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      finish     = 1'b0;
      push.count = 2'd0;
      push.first = '0;
      push.second = '0;

      // header fields land first so results of this byte see them
      if (phase_ff == PH_HEADER) begin
         unique case (offset_ff)
            16'd0:   code_in  = data_byte;
            16'd1:   ident_in = data_byte;
            16'd2:   limit_in = {data_byte, 8'd0};
            16'd3:   limit_in = {limit_ff[15:8], data_byte};
            default: ;
         endcase
      end
      if (phase_ff == PH_TYPE) begin
         type_in   = data_byte;
         length_in = 8'd0;
         count_in  = 8'd0;
      end
      if (phase_ff == PH_LENGTH) begin
         length_in = data_byte;
      end

      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_done) begin
               push.first = make_result(K_HEADER, 1'b0, code_in, ident_in, limit_in,
                                        type_in, length_in, 8'd0, 8'd0, 1'b0);
               if (last_byte || (limit_in <= 16'(HEADER_BYTES))) begin
                  push.second = make_result(K_END, 1'b0, code_in, ident_in, limit_in,
                                            type_in, length_in, 8'd0, 8'd0, 1'b0);
                  push.count  = 2'd2;
                  finish      = 1'b1;
               end else begin
                  push.count = 2'd1;
                  phase_in   = PH_TYPE;
               end
            end else if (last_byte) begin
               push.first = make_result(K_TRUNC, 1'b0, code_in, ident_in, limit_in,
                                        type_in, length_in, 8'd0, 8'd0, 1'b0);
               push.count = 2'd1;
               finish     = 1'b1;
            end
         end
         PH_TYPE: begin
            if (stop) begin
               push.first = make_result(K_TRUNC, 1'b1, code_in, ident_in, limit_in,
                                        type_in, length_in, 8'd0, 8'd0, 1'b0);
               push.count = 2'd1;
               finish     = 1'b1;
            end else begin
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            if (data_byte < MIN_ATTR_LEN) begin
               push.first = make_result(K_MALFORMED, 1'b1, code_in, ident_in, limit_in,
                                        type_in, length_in, 8'd0, 8'd0, 1'b0);
               push.count = 2'd1;
               finish     = 1'b1;
            end else if (data_byte == MIN_ATTR_LEN) begin
               push.first = make_result(K_EMPTY, 1'b1, code_in, ident_in, limit_in,
                                        type_in, length_in, 8'd0, 8'd0, 1'b0);
               if (stop) begin
                  push.second = make_result(K_END, 1'b0, code_in, ident_in, limit_in,
                                            type_in, length_in, 8'd0, 8'd0, 1'b0);
                  push.count  = 2'd2;
                  finish      = 1'b1;
               end else begin
                  push.count = 2'd1;
                  phase_in   = PH_TYPE;
               end
            end else if (stop) begin
               push.first = make_result(K_TRUNC, 1'b1, code_in, ident_in, limit_in,
                                        type_in, length_in, 8'd0, 8'd0, 1'b0);
               push.count = 2'd1;
               finish     = 1'b1;
            end else begin
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            push.first = make_result(K_VALUE, 1'b1, code_in, ident_in, limit_in,
                                     type_in, length_in, data_byte, count_ff, fin);
            count_in   = count_ff + 8'd1;
            if (fin) begin
               if (stop) begin
                  push.second = make_result(K_END, 1'b0, code_in, ident_in, limit_in,
                                            type_in, length_in, 8'd0, 8'd0, 1'b0);
                  push.count  = 2'd2;
                  finish      = 1'b1;
               end else begin
                  push.count = 2'd1;
                  phase_in   = PH_TYPE;
               end
            end else if (stop) begin
               push.second = make_result(K_TRUNC, 1'b1, code_in, ident_in, limit_in,
                                         type_in, length_in, 8'd0, 8'd0, 1'b0);
               push.count  = 2'd2;
               finish      = 1'b1;
            end else begin
               push.count = 2'd1;
            end
         end
         PH_DONE: ;
         default: ;
      endcase

      offset_in = (offset_ff == 16'hFFFF) ? offset_ff : off_inc[15:0];
      if (finish) begin
         phase_in = PH_DONE;
      end
      // a marked byte closes the packet: start clean on the next one
      if (last_byte) begin
         phase_in  = PH_HEADER;
         offset_in = 16'd0;
         limit_in  = 16'd0;
         code_in   = 8'd0;
         ident_in  = 8'd0;
         type_in   = 8'd0;
         length_in = 8'd0;
         count_in  = 8'd0;
      end
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         offset_ff <= 16'd0;
         limit_ff  <= 16'd0;
         code_ff   <= 8'd0;
         ident_ff  <= 8'd0;
         type_ff   <= 8'd0;
         length_ff <= 8'd0;
         count_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         limit_ff  <= limit_in;
         code_ff   <= code_in;
         ident_ff  <= ident_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/rap_fifo.sv
// Result queue: takes up to two results a cycle, gives one a cycle.
// Depends on rap_pkg.
module rap_fifo (
   input  logic                clock,
   input  logic                reset,
   input  rap_pkg::push_type   push,
   input  logic                pop,
   output rap_pkg::result_type head,
   output logic                not_empty,
   output logic                room
);
   import rap_pkg::*;

   localparam int PTR_W = $clog2(RESULT_DEPTH);
   localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

   result_type       mem_ff [RESULT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;

   assign wr_next   = wr_ptr_ff + PTR_W'(1);
   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign room      = count_ff <= CNT_W'(RESULT_DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule

### rtl/radius_attribute_stream_parser.sv
// RADIUS attribute stream parser: one payload byte per beat in, parse results out.
// A byte's results are registered in the result queue, then leave it on rsp_tvalid.
// Throughput: one byte per cycle; a byte with two results gives two output beats,
// and the four-beat result queue takes a byte only while two slots are free.
// Reset (synchronous, active high) empties the queue and returns to the header.
// Depends on rap_pkg, rap_step and rap_fifo.
module radius_attribute_stream_parser #(
   parameter int HEADER_BYTES = 20
) (
   input  logic        clock,
   input  logic        reset,
   // payload byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // parse results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] packet_code, [15:8] packet_identifier, [31:16] header_length,
   // [39:32] attr_type, [47:40] attr_length, [55:48] value_byte, [63:56] value_index
   output logic [63:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // last_of_attr
);
   import rap_pkg::*;

   logic       req_accept;
   logic       rsp_accept;
   logic       queue_room;
   push_type   push;
   result_type head;

   // take a byte whenever the queue can absorb its worst case of two results
   assign req_tready = queue_room;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   rap_step #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .push      (push)
   );

   rap_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_accept),
      .head      (head),
      .not_empty (rsp_tvalid),
      .room      (queue_room)
   );

   // pack the head result onto the output beat
   assign rsp_tdata = {head.value_index, head.value_byte, head.attr_length, head.attr_type,
                       head.header_length, head.packet_identifier, head.packet_code};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_of_attr;

endmodule

### rtl/rap_checker.sv
// Port-level checks for the RADIUS attribute stream parser, bound to the top level.
// Depends on rap_pkg and radius_attribute_stream_parser_defines.svh.
`include "radius_attribute_stream_parser_defines.svh"

module rap_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import rap_pkg::*;

   `RAP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result beat changed while stalled")
   `RAP_ASSERT_NEXT(a_full_holds, !req_tready && !rsp_tready, !req_tready, "input reopened while the result side stalls")
   `RAP_ASSERT_NOW(a_kind_range, rsp_tvalid, rsp_tuser <= K_END, "result kind out of range")
   `RAP_ASSERT_NOW(a_last_on_value, rsp_tvalid && rsp_tlast, rsp_tuser == K_VALUE, "tlast on a non-value result")
   `RAP_ASSERT_NOW(a_value_clear, rsp_tvalid && (rsp_tuser != K_VALUE), rsp_tdata[63:48] == 16'd0, "value fields set on a non-value result")

endmodule

bind radius_attribute_stream_parser rap_checker u_rap_checker (.*);

### test/radius_attribute_stream_parser_tb.sv
// Self-checking bench for radius_attribute_stream_parser: streams RADIUS payloads
// and compares every parse result with a behavioral predictor.
// Depends on rap_pkg and the parser RTL.
module radius_attribute_stream_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rap_pkg::*;

   localparam int HEADER_BYTES = 20;
   localparam int TARGET_BYTES = 1450;
   localparam int HOLD_CYCLES  = 300;

   // Predicts the parse results of each accepted byte and holds them until
   // the matching result beat comes out of the block.
   class parse_result_board_type;
      phase_type   phase;
      logic [15:0] offset;
      logic [15:0] limit;
      logic [7:0]  code;
      logic [7:0]  ident;
      logic [7:0]  cur_type;
      logic [7:0]  cur_len;
      logic [7:0]  value_count;
      result_type  pending_results[$];
      int          mismatch_count;
      int          checked_count;
      int          kind_seen[6];

      function new();
         mismatch_count = 0;
         checked_count  = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
         start_packet();
      endfunction

      function void start_packet();
         phase       = PH_HEADER;
         offset      = '0;
         limit       = '0;
         code        = '0;
         ident       = '0;
         cur_type    = '0;
         cur_len     = '0;
         value_count = '0;
      endfunction

      function void add_result(kind_type k, bit with_attr, logic [7:0] vbyte,
                               logic [7:0] vidx, logic vlast);
         result_type r;
         r.kind              = k;
         r.packet_code       = code;
         r.packet_identifier = ident;
         r.header_length     = limit;
         r.attr_type         = with_attr ? cur_type : 8'd0;
         r.attr_length       = with_attr ? cur_len : 8'd0;
         r.value_byte        = vbyte;
         r.value_index       = vidx;
         r.last_of_attr      = vlast;
         pending_results.push_back(r);
      endfunction

      // Advance the parse state by one accepted byte.
      function void take_byte(logic [7:0] b, logic last);
         logic [16:0] next_off;
         logic [7:0]  vlen;
         bit          stop;
         bit          finish;
         bit          fin;
         next_off = {1'b0, offset} + 17'd1;
         stop     = last || (next_off >= {1'b0, limit});
         finish   = 0;
         case (phase)
            PH_HEADER: begin
               if (offset == 16'd0) code = b;
               else if (offset == 16'd1) ident = b;
               else if (offset == 16'd2) limit = {b, 8'h00};
               else if (offset == 16'd3) limit[7:0] = b;
               if (next_off >= HEADER_BYTES) begin
                  add_result(K_HEADER, 0, 8'd0, 8'd0, 1'b0);
                  if (last || limit <= HEADER_BYTES) begin
                     add_result(K_END, 0, 8'd0, 8'd0, 1'b0);
                     finish = 1;
                  end else begin
                     phase = PH_TYPE;
                  end
               end else if (last) begin
                  add_result(K_TRUNC, 0, 8'd0, 8'd0, 1'b0);
                  finish = 1;
               end
            end
            PH_TYPE: begin
               cur_type    = b;
               cur_len     = 8'd0;
               value_count = 8'd0;
               if (stop) begin
                  add_result(K_TRUNC, 1, 8'd0, 8'd0, 1'b0);
                  finish = 1;
               end else begin
                  phase = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               cur_len = b;
               if (b < MIN_ATTR_LEN) begin
                  add_result(K_MALFORMED, 1, 8'd0, 8'd0, 1'b0);
                  finish = 1;
               end else if (b == MIN_ATTR_LEN) begin
                  add_result(K_EMPTY, 1, 8'd0, 8'd0, 1'b0);
                  if (stop) begin
                     add_result(K_END, 0, 8'd0, 8'd0, 1'b0);
                     finish = 1;
                  end else begin
                     phase = PH_TYPE;
                  end
               end else if (stop) begin
                  add_result(K_TRUNC, 1, 8'd0, 8'd0, 1'b0);
                  finish = 1;
               end else begin
                  phase = PH_VALUE;
               end
            end
            PH_VALUE: begin
               vlen = cur_len - MIN_ATTR_LEN;
               fin  = ({1'b0, value_count} + 9'd1) >= {1'b0, vlen};
               add_result(K_VALUE, 1, b, value_count, fin);
               value_count = value_count + 8'd1;
               if (fin) begin
                  if (stop) begin
                     add_result(K_END, 0, 8'd0, 8'd0, 1'b0);
                     finish = 1;
                  end else begin
                     phase = PH_TYPE;
                  end
               end else if (stop) begin
                  add_result(K_TRUNC, 1, 8'd0, 8'd0, 1'b0);
                  finish = 1;
               end
            end
            default: ;
         endcase
         if (offset != 16'hFFFF) offset = offset + 16'd1;
         if (finish) phase = PH_DONE;
         if (last) start_packet();
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_result(logic [63:0] tdata, logic [2:0] tuser, logic tlast);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: kind %0d, data 0x%0h", tuser, tdata);
            mismatch_count++;
            return;
         end
         want = pending_results.pop_front();
         checked_count++;
         kind_seen[int'(want.kind)]++;
         compare_field("kind",              16'(want.kind),              16'(tuser));
         compare_field("packet_code",       16'(want.packet_code),       16'(tdata[7:0]));
         compare_field("packet_identifier", 16'(want.packet_identifier), 16'(tdata[15:8]));
         compare_field("header_length",     want.header_length,          tdata[31:16]);
         compare_field("attr_type",         16'(want.attr_type),         16'(tdata[39:32]));
         compare_field("attr_length",       16'(want.attr_length),       16'(tdata[47:40]));
         compare_field("value_byte",        16'(want.value_byte),        16'(tdata[55:48]));
         compare_field("value_index",       16'(want.value_index),       16'(tdata[63:56]));
         compare_field("last_of_attr",      16'(want.last_of_attr),      16'(tlast));
      endfunction
   endclass

   typedef struct {
      logic [7:0] data;
      logic       last;
      int         gap;
   } payload_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [7:0] packet_code, [15:8] packet_identifier, [31:16] header_length,
   // [39:32] attr_type, [47:40] attr_length, [55:48] value_byte, [63:56] value_index
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;    // kind
   logic        rsp_tlast;    // last_of_attr

   parse_result_board_type board = new();
   payload_beat_type       payload_beats[$];
   logic [7:0]             attr_bytes[$];
   int                     packet_count = 0;
   int                     bytes_sent = 0;
   bit                     hold_done = 0;

   radius_attribute_stream_parser #(
      .HEADER_BYTES (HEADER_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Lean on the extremes of a byte a quarter of the time.
   function automatic logic [7:0] pick_octet();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void queue_beat(logic [7:0] data, logic last, int gap);
      payload_beat_type beat;
      beat.data = data;
      beat.last = last;
      beat.gap  = gap;
      payload_beats.push_back(beat);
   endfunction

   // Build an attribute list into attr_bytes; optionally slip in one attribute
   // whose length byte is below the minimum.
   function automatic void build_attrs(int count, bit with_malformed);
      int bad_at;
      int len;
      int r;
      attr_bytes.delete();
      bad_at = with_malformed ? int'($urandom_range(0, count - 1)) : -1;
      for (int i = 0; i < count; i++) begin
         attr_bytes.push_back(pick_octet());
         if (i == bad_at) begin
            attr_bytes.push_back(8'($urandom_range(0, 1)));
            continue;
         end
         r = $urandom_range(0, 99);
         if (r < 15) len = 2;
         else if (r < 97) len = $urandom_range(3, 12);
         else len = $urandom_range(200, 255);
         attr_bytes.push_back(8'(len));
         for (int j = 0; j < len - 2; j++) attr_bytes.push_back(8'($urandom));
      end
   endfunction

   // Header with the given length field, then attr_bytes, then filler;
   // sent_len bytes in all with the last one marked.
   function automatic void queue_packet(logic [15:0] length_field, int sent_len);
      bit         burst;
      logic [7:0] b;
      logic [7:0] code;
      logic [7:0] ident;
      burst = ($urandom_range(0, 3) == 0);
      code  = pick_octet();
      ident = pick_octet();
      for (int i = 0; i < sent_len; i++) begin
         if (i == 0) b = code;
         else if (i == 1) b = ident;
         else if (i == 2) b = length_field[15:8];
         else if (i == 3) b = length_field[7:0];
         else if (i < HEADER_BYTES) b = 8'($urandom);
         else if (i - HEADER_BYTES < attr_bytes.size()) b = attr_bytes[i - HEADER_BYTES];
         else b = 8'($urandom);
         queue_beat(b, i == sent_len - 1, burst ? 0 : idle_len());
      end
      packet_count++;
   endfunction

   function automatic void build_stimulus();
      int round;
      int scenario;
      int nattr;
      int body;
      // Directed: packet cut after one byte, cut inside the length field, and a
      // bare header whose length equals the header size.
      queue_beat(8'hFF, 1'b1, 0);
      queue_beat(8'h00, 1'b0, 0);
      queue_beat(8'hA5, 1'b0, 0);
      queue_beat(8'hFF, 1'b1, 0);
      for (int i = 0; i < HEADER_BYTES; i++) begin
         queue_beat((i == 0) ? 8'hFF : (i == 3) ? 8'(HEADER_BYTES) :
                    (i < 3) ? 8'h00 : 8'($urandom), i == HEADER_BYTES - 1, 0);
      end
      packet_count += 3;
      // Random: walk every packet shape once, then pick shapes at random.
      round = 0;
      while (payload_beats.size() < TARGET_BYTES + 24) begin
         scenario = (round < 8) ? round : int'($urandom_range(0, 7));
         round++;
         nattr = $urandom_range(1, 6);
         build_attrs(nattr, scenario == 5);
         body = attr_bytes.size();
         case (scenario)
            // length matches the bytes sent
            0, 5: queue_packet(16'(HEADER_BYTES + body), HEADER_BYTES + body);
            // trailing bytes past the length, ignored
            1: queue_packet(16'(HEADER_BYTES + body),
                            HEADER_BYTES + body + int'($urandom_range(1, 6)));
            // payload ends before the length says
            2: queue_packet(($urandom_range(0, 4) == 0) ? 16'hFFFF :
                            16'(HEADER_BYTES + body + int'($urandom_range(1, 40))),
                            HEADER_BYTES + int'($urandom_range(1, body)));
            // length no larger than the header
            3: queue_packet(16'($urandom_range(0, HEADER_BYTES)),
                            HEADER_BYTES + int'($urandom_range(0, body)));
            // ends inside the header
            4: queue_packet(16'($urandom), int'($urandom_range(1, HEADER_BYTES - 1)));
            // length ends inside the attribute list
            6: queue_packet(16'(HEADER_BYTES + int'($urandom_range(1, body - 1))),
                            HEADER_BYTES + body);
            default: begin
               attr_bytes.delete();
               repeat ($urandom_range(1, 40)) attr_bytes.push_back(8'($urandom));
               queue_packet(16'($urandom), HEADER_BYTES + attr_bytes.size());
            end
         endcase
      end
   endfunction

   // Offer each byte, hold it until accepted, and log it with the predictor.
   task automatic send_payload();
      payload_beat_type beat;
      while (payload_beats.size() != 0) begin
         beat = payload_beats.pop_front();
         if (beat.gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (beat.gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= beat.data;
         req_tlast  <= beat.last;
         do @(posedge clock); while (!req_tready);
         board.take_byte(beat.data, beat.last);
         bytes_sent++;
         @(negedge clock);
      end
      req_tvalid <= 1'b0;
   endtask

   // Result side: random ready pattern, plus one long hold-off so the result
   // queue fills and the input stalls.
   initial begin
      int run;
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && bytes_sent >= 150) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1;
         end else begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
            rsp_tready <= 1'b1;
            repeat (run) @(negedge clock);
            stall = idle_len();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
      end
   end

   // Check every result beat at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      build_stimulus();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      send_payload();
      // drain: wait for every predicted result, then watch for strays
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d payload bytes in %0d packets; %0d results checked.",
               bytes_sent, packet_count, board.checked_count);
      $display("Results: header %0d, value %0d, empty %0d, truncated %0d, malformed %0d, end %0d",
               board.kind_seen[K_HEADER], board.kind_seen[K_VALUE],
               board.kind_seen[K_EMPTY], board.kind_seen[K_TRUNC],
               board.kind_seen[K_MALFORMED], board.kind_seen[K_END]);
      if (board.mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
